// ----- design/ps2_mouse_packet_event_queue_macros.svh -----
// ---------------------------------------------------------------------------
// Mouse packet event queue assertion macros
// Shared concurrent assertion shorthands, clocked on clk, reset by arst_n.
// ---------------------------------------------------------------------------
`ifndef PS2_MOUSE_PACKET_EVENT_QUEUE_MACROS_SVH
`define PS2_MOUSE_PACKET_EVENT_QUEUE_MACROS_SVH

// Same-cycle implication.
`define PS2MQ_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define PS2MQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- design/ps2mq_pkg.sv -----
// ---------------------------------------------------------------------------
// Mouse packet event queue package
// Sizes, opcodes, event types and saturating helpers.
// ---------------------------------------------------------------------------
package ps2mq_pkg;

	localparam int RING_DEPTH = 64;
	localparam int SUM_WIDTH  = 16;
	localparam int PTR_W      = $clog2(RING_DEPTH);
	// a fresh event may hold dy = +256, so fields never go below 10 bits
	localparam int FIELD_W    = (SUM_WIDTH > 10) ? SUM_WIDTH : 10;
	localparam int OUT_W      = 16;
	localparam int OUT_TDATA_W = 56;

	localparam logic OP_FEED = 1'b0;
	localparam logic OP_POP  = 1'b1;

	localparam logic signed [FIELD_W:0] SAT_MAX =
		(FIELD_W+1)'((longint'(1) <<< (SUM_WIDTH - 1)) - 1);
	localparam logic signed [FIELD_W:0] SAT_MIN = ~SAT_MAX;

	typedef struct packed {
		logic signed [FIELD_W-1:0] dz;
		logic signed [FIELD_W-1:0] dy;
		logic signed [FIELD_W-1:0] dx;
		logic [2:0]                buttons;
	} pkt_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] dz;
		logic signed [FIELD_W-1:0] dy;
		logic signed [FIELD_W-1:0] dx;
		logic [2:0]                buttons;
		logic                      chg;
	} ev_t;

	localparam int EV_W = $bits(ev_t);

	typedef struct packed {
		logic [2:0]       buttons;
		logic [OUT_W-1:0] wheel;
		logic [OUT_W-1:0] y;
		logic [OUT_W-1:0] x;
	} res_t;

	function automatic logic signed [FIELD_W-1:0] sat_add(
		input logic signed [FIELD_W-1:0] a,
		input logic signed [FIELD_W-1:0] b
	);
		logic signed [FIELD_W:0] s;
		s = {a[FIELD_W-1], a} + {b[FIELD_W-1], b};
		if (s > SAT_MAX)
			s = SAT_MAX;
		else if (s < SAT_MIN)
			s = SAT_MIN;
		return s[FIELD_W-1:0];
	endfunction

	function automatic logic [OUT_W-1:0] to_out(input logic signed [FIELD_W-1:0] v);
		logic signed [31:0] w;
		w = 32'(v);
		return w[OUT_W-1:0];
	endfunction

endpackage

// ----- design/ps2mq_ram.sv -----
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module ps2mq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- design/ps2mq_asm.sv -----
// ---------------------------------------------------------------------------
// Mouse packet assembler
// Collect port bytes into packets and decode finished packets.
// ---------------------------------------------------------------------------
module ps2mq_asm (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            feed,
	input  logic [7:0]      port_byte,
	input  logic            wheel_mode,
	output logic            pkt_valid,
	output ps2mq_pkg::pkt_t pkt
);
	import ps2mq_pkg::*;

	logic [1:0] pos_q;
	logic [7:0] b0_q, b1_q, b2_q;
	logic       start_ok, complete;
	logic [7:0] flags, y_byte;

	assign start_ok = (pos_q != 2'd0) || port_byte[3];
	assign complete = (pos_q == 2'd3) || ((pos_q == 2'd2) && !wheel_mode);
	assign flags    = b0_q;
	assign y_byte   = (pos_q == 2'd2) ? port_byte : b2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 2'd0;
		end else if (feed && start_ok) begin
			pos_q <= complete ? 2'd0 : pos_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (feed && start_ok) begin
			unique case (pos_q)
				2'd0: b0_q <= port_byte;
				2'd1: b1_q <= port_byte;
				2'd2: b2_q <= port_byte;
				default: ;
			endcase
		end
	end

	// drop packets that carry an overflow flag
	assign pkt_valid = feed && start_ok && complete && (flags[7:6] == 2'b00);

	always_comb begin
		logic signed [FIELD_W-1:0] y_raw;
		pkt.dx = {{(FIELD_W-9){flags[4]}}, flags[4], b1_q};
		y_raw  = {{(FIELD_W-9){flags[5]}}, flags[5], y_byte};
		pkt.dy = -y_raw;
		if (wheel_mode && (pos_q == 2'd3))
			pkt.dz = {{(FIELD_W-4){port_byte[3]}}, port_byte[3:0]};
		else
			pkt.dz = '0;
		pkt.buttons = flags[2:0];
	end

endmodule

// ----- design/ps2mq_ring.sv -----
// ---------------------------------------------------------------------------
// Mouse event ring
// Push, merge-on-full and pop over one event memory.
// ---------------------------------------------------------------------------
`include "ps2_mouse_packet_event_queue_macros.svh"

module ps2mq_ring (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	input  ps2mq_pkg::pkt_t push_pkt,
	input  logic            pop_req,
	output logic            idle,
	output logic            res_valid,
	input  logic            res_ready,
	output ps2mq_pkg::res_t res
);
	import ps2mq_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_MERGE = 2'd1;
	localparam logic [1:0] ST_POP   = 2'd2;

	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

	logic [1:0]       state_q;
	logic [PTR_W-1:0] head_q, tail_q, mrg_addr_q;
	logic [2:0]       cur_btn_q;
	ev_t              ev_q;
	logic             out_valid_q;
	res_t             out_q;

	logic [PTR_W-1:0] head_nxt, head_prv, tail_nxt;
	logic             full, empty, chg;
	ev_t              new_ev, rd_ev, mrg_ev;
	logic             we, re;
	logic [PTR_W-1:0] waddr, raddr;
	logic [EV_W-1:0]  wdata, rdata;
	logic             quiet, out_free;

	assign head_nxt = (head_q == PTR_LAST) ? '0 : head_q + PTR_W'(1);
	assign head_prv = (head_q == '0) ? PTR_LAST : head_q - PTR_W'(1);
	assign tail_nxt = (tail_q == PTR_LAST) ? '0 : tail_q + PTR_W'(1);
	assign full     = (head_nxt == tail_q);
	assign empty    = (head_q == tail_q);
	assign chg      = (push_pkt.buttons != cur_btn_q);

	assign new_ev = '{dz: push_pkt.dz, dy: push_pkt.dy, dx: push_pkt.dx,
		buttons: push_pkt.buttons, chg: chg};

	assign rd_ev = ev_t'(rdata);

	assign mrg_ev = '{dz: sat_add(rd_ev.dz, ev_q.dz), dy: sat_add(rd_ev.dy, ev_q.dy),
		dx: sat_add(rd_ev.dx, ev_q.dx), buttons: ev_q.buttons, chg: rd_ev.chg | ev_q.chg};

	assign idle = (state_q == ST_IDLE);

	always_comb begin
		we    = 1'b0;
		re    = 1'b0;
		waddr = head_q;
		raddr = tail_q;
		wdata = new_ev;
		unique case (state_q)
			ST_IDLE: begin
				if (push_valid && !full) begin
					we = 1'b1;
				end else if (push_valid) begin
					re    = 1'b1;
					raddr = head_prv;
				end else if (pop_req && !empty) begin
					re = 1'b1;
				end
			end
			ST_MERGE: begin
				we    = 1'b1;
				waddr = mrg_addr_q;
				wdata = mrg_ev;
			end
			default: ;
		endcase
	end

	ps2mq_ram #(.WIDTH(EV_W), .DEPTH(RING_DEPTH)) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign quiet    = (rd_ev.dx == '0) && (rd_ev.dy == '0) && (rd_ev.dz == '0) && !rd_ev.chg;
	assign out_free = !out_valid_q || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			cur_btn_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && res_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (push_valid) begin
						cur_btn_q <= push_pkt.buttons;
						if (full)
							state_q <= ST_MERGE;
						else
							head_q <= head_nxt;
					end else if (pop_req && !empty) begin
						tail_q  <= tail_nxt;
						state_q <= ST_POP;
					end
				end
				ST_MERGE: state_q <= ST_IDLE;
				ST_POP: begin
					// hold the read data until the output slot frees up
					if (quiet) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (idle && push_valid && full) begin
			ev_q       <= new_ev;
			mrg_addr_q <= head_prv;
		end
		if ((state_q == ST_POP) && !quiet && out_free) begin
			out_q.x       <= to_out(rd_ev.dx);
			out_q.y       <= to_out(rd_ev.dy);
			out_q.wheel   <= to_out(rd_ev.dz);
			out_q.buttons <= rd_ev.buttons;
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

	`PS2MQ_ASSERT_NOW(a_busy_no_request, !idle, !push_valid && !pop_req)
	`PS2MQ_ASSERT_NOW(a_merge_newest, state_q == ST_MERGE, mrg_addr_q == head_prv && full)
	`PS2MQ_ASSERT_NEXT(a_merge_keeps_ptrs, state_q == ST_MERGE,
		$stable(head_q) && $stable(tail_q))
	`PS2MQ_ASSERT_NEXT(a_push_not_empty, idle && push_valid, head_q != tail_q)

endmodule

// ----- design/ps2_mouse_packet_event_queue.sv -----
// ---------------------------------------------------------------------------
// Mouse packet event queue
// Assemble mouse port bytes into packets and queue decoded motion events.
// ---------------------------------------------------------------------------
//  Channel   Dir  Contents
//  s_axis    in   tuser: opcode (0 feed byte, 1 pop event); tdata: port_byte
//  m_axis    out  tdata: motion_x, motion_y, wheel_steps, button_bits
//  cfg       in   wheel_mode write (write enable, 1-bit data)
//
//  A feed writes straight into the ring; a feed that lands on a full ring also
//  passes through the merge state (read the newest entry, write back the merged
//  sums). A pop of a queued event reads the memory, then loads the output
//  register in the pop state and holds there only while an earlier result sits
//  unclaimed in it. A pop on an empty ring leaves the engine idle.
//  Reset clears pointers, packet position and button history; ring contents
//  are not cleared, so there is no startup sweep.
// ---------------------------------------------------------------------------
module ps2_mouse_packet_event_queue (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [7:0]                           s_axis_tdata,  // [7:0] port_byte
	input  logic                                 s_axis_tuser,  // [0] opcode
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// [15:0] motion_x, [31:16] motion_y, [47:32] wheel_steps, [50:48] button_bits
	output logic [ps2mq_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	input  logic                                 cfg_wr_en,
	input  logic                                 cfg_wr_data
);
	import ps2mq_pkg::*;

	logic wheel_mode_q;
	logic accept, feed, pop_req;
	logic idle;
	logic pkt_valid;
	pkt_t pkt;
	res_t res;

	// the user changes wheel mode only while the queue is idle; the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wheel_mode_q <= 1'b0;
		end else if (cfg_wr_en) begin
			wheel_mode_q <= cfg_wr_data;
		end
	end

	// take a request only when the ring engine has no access in flight
	assign s_axis_tready = idle;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign feed          = accept && (s_axis_tuser == OP_FEED);
	assign pop_req       = accept && (s_axis_tuser == OP_POP);

	ps2mq_asm u_asm (
		.clk       (clk),
		.arst_n    (arst_n),
		.feed      (feed),
		.port_byte (s_axis_tdata),
		.wheel_mode(wheel_mode_q),
		.pkt_valid (pkt_valid),
		.pkt       (pkt)
	);

	ps2mq_ring u_ring (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(pkt_valid),
		.push_pkt  (pkt),
		.pop_req   (pop_req),
		.idle      (idle),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res       (res)
	);

	// pack result fields low to high, pad to whole bytes
	assign m_axis_tdata = {{(OUT_TDATA_W - $bits(res_t)){1'b0}},
		res.buttons, res.wheel, res.y, res.x};

endmodule

// ----- tb/tb.sv -----
// ---------------------------------------------------------------------------
// Mouse packet event queue testbench
// Stream mouse port bytes and pop requests into the block, keep a cycle-free
// model of packet assembly and the event ring, and compare every popped
// report field by field. A short table of hand-checked cases comes first.
// Random packet traffic in both packet lengths follows, around a flood that
// fills the ring and saturates the merged sums while the receiver holds off.
// ---------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ps2mq_pkg::*;

	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int FLOOD_MERGES  = 140;

	// Row kinds of the directed table.
	typedef enum logic [1:0] {
		ROW_PRED,  // check against the model
		ROW_NONE,  // no report may come from this request
		ROW_LIT,   // the report is typed in the row
		ROW_MODE   // write wheel_mode with data[0] once the block is idle
	} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic        op;
		logic [7:0]  data;
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] wheel;
		logic [2:0]  buttons;
	} dir_row_t;

	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] wheel;
		logic [2:0]  buttons;
	} motion_report_t;

	typedef struct {
		int         dx;
		int         dy;
		int         dz;
		logic [2:0] buttons;
		logic       chg;
	} mouse_move_t;

	localparam int DIR_ROWS = 25;

	dir_row_t dir_table [DIR_ROWS] = '{
		// pop on an empty ring, then a stray byte with bit 3 clear
		'{ROW_NONE, OP_POP,  8'h00, 16'h0000, 16'h0000, 16'h0000, 3'd0},
		'{ROW_NONE, OP_FEED, 8'h00, 16'h0000, 16'h0000, 16'h0000, 3'd0},
		// quiet packet: no motion, no button change, popped silently
		'{ROW_NONE, OP_FEED, 8'h08, 16'h0000, 16'h0000, 16'h0000, 3'd0},
		'{ROW_NONE, OP_FEED, 8'h00, 16'h0000, 16'h0000, 16'h0000, 3'd0},
		'{ROW_NONE, OP_FEED, 8'h00, 16'h0000, 16'h0000, 16'h0000, 3'd0},
		'{ROW_NONE, OP_POP,  8'h00, 16'h0000, 16'h0000, 16'h0000, 3'd0},
		// both overflow flags: packet dropped
		'{ROW_NONE, OP_FEED, 8'hC8, 16'h0000, 16'h0000, 16'h0000, 3'd0},
		'{ROW_NONE, OP_FEED, 8'h10, 16'h0000, 16'h0000, 16'h0000, 3'd0},
		'{ROW_NONE, OP_FEED, 8'h10, 16'h0000, 16'h0000, 16'h0000, 3'd0},
		// most negative dx and dy, all buttons down
		'{ROW_NONE, OP_FEED, 8'h3F, 16'h0000, 16'h0000, 16'h0000, 3'd0},
		'{ROW_NONE, OP_FEED, 8'h00, 16'h0000, 16'h0000, 16'h0000, 3'd0},
		'{ROW_NONE, OP_FEED, 8'h00, 16'h0000, 16'h0000, 16'h0000, 3'd0},
		'{ROW_LIT,  OP_POP,  8'h00, 16'hFF00, 16'h0100, 16'h0000, 3'd7},
		// wheel packets: most positive dx, wheel +7
		'{ROW_MODE, OP_FEED, 8'h01, 16'h0000, 16'h0000, 16'h0000, 3'd0},
		'{ROW_NONE, OP_FEED, 8'h0A, 16'h0000, 16'h0000, 16'h0000, 3'd0},
		'{ROW_NONE, OP_FEED, 8'hFF, 16'h0000, 16'h0000, 16'h0000, 3'd0},
		'{ROW_NONE, OP_FEED, 8'hFF, 16'h0000, 16'h0000, 16'h0000, 3'd0},
		'{ROW_NONE, OP_FEED, 8'h07, 16'h0000, 16'h0000, 16'h0000, 3'd0},
		'{ROW_LIT,  OP_POP,  8'h00, 16'h00FF, 16'hFF01, 16'h0007, 3'd2},
		// three bytes, then back to short packets: the fourth byte closes it
		'{ROW_NONE, OP_FEED, 8'h0C, 16'h0000, 16'h0000, 16'h0000, 3'd0},
		'{ROW_NONE, OP_FEED, 8'h10, 16'h0000, 16'h0000, 16'h0000, 3'd0},
		'{ROW_NONE, OP_FEED, 8'h20, 16'h0000, 16'h0000, 16'h0000, 3'd0},
		'{ROW_MODE, OP_FEED, 8'h00, 16'h0000, 16'h0000, 16'h0000, 3'd0},
		'{ROW_NONE, OP_FEED, 8'hFF, 16'h0000, 16'h0000, 16'h0000, 3'd0},
		'{ROW_LIT,  OP_POP,  8'h00, 16'h0010, 16'hFFE0, 16'h0000, 3'd4}
	};

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [7:0]             s_axis_tdata = 8'h00;
	logic                   s_axis_tuser = OP_FEED;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   cfg_wr_en = 1'b0;
	logic                   cfg_wr_data = 1'b0;

	// Model state: packet assembly, button history, event ring.
	logic        mdl_wheel_mode;
	logic [7:0]  mdl_pkt [3];
	int unsigned mdl_pos;
	logic [2:0]  mdl_buttons;
	mouse_move_t mdl_ring [RING_DEPTH];
	int unsigned mdl_head;
	int unsigned mdl_tail;

	motion_report_t pending_reports [$];

	// Traffic control and bookkeeping.
	logic no_idle = 1'b0;
	int   hold_req = 0;
	int   items_sent = 0;
	int   reports_seen = 0;
	int   mismatches = 0;
	int   merge_count = 0;
	int   clip_count = 0;
	int   quiet_pops = 0;

	ps2_mouse_packet_event_queue uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data)
	);

	initial forever #4 clk = ~clk;

	// Backstop: end the run if anything hangs.
	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

	// ------------------------------------------------------------------
	// Model
	// ------------------------------------------------------------------

	function automatic int unsigned ring_succ(input int unsigned i);
		return (i + 1 >= RING_DEPTH) ? 0 : i + 1;
	endfunction

	// Add two sums and clip to the signed SUM_WIDTH range.
	function automatic int clip_sum(input int a, input int b);
		longint hi;
		longint lo;
		longint s;
		hi = (longint'(1) <<< (SUM_WIDTH - 1)) - 1;
		lo = -hi - 1;
		s = longint'(a) + longint'(b);
		if (s > hi || s < lo)
			clip_count++;
		if (s > hi)
			s = hi;
		if (s < lo)
			s = lo;
		return int'(s);
	endfunction

	// Append a decoded packet, or fold it into the newest entry when full.
	function automatic void queue_move(input int dx, input int dy, input int dz,
			input logic [2:0] btn);
		int unsigned nxt;
		int unsigned newest;
		logic chg;
		nxt = ring_succ(mdl_head);
		chg = (btn != mdl_buttons);
		mdl_buttons = btn;
		if (nxt == mdl_tail) begin
			newest = (mdl_head == 0) ? RING_DEPTH - 1 : mdl_head - 1;
			mdl_ring[newest].dx = clip_sum(mdl_ring[newest].dx, dx);
			mdl_ring[newest].dy = clip_sum(mdl_ring[newest].dy, dy);
			mdl_ring[newest].dz = clip_sum(mdl_ring[newest].dz, dz);
			mdl_ring[newest].buttons = btn;
			mdl_ring[newest].chg = mdl_ring[newest].chg | chg;
			merge_count++;
			return;
		end
		mdl_ring[mdl_head].dx = dx;
		mdl_ring[mdl_head].dy = dy;
		mdl_ring[mdl_head].dz = dz;
		mdl_ring[mdl_head].buttons = btn;
		mdl_ring[mdl_head].chg = chg;
		mdl_head = nxt;
	endfunction

	function automatic void absorb_byte(input logic [7:0] b);
		int unsigned plen;
		logic [7:0] flags;
		int dx;
		int dy;
		int dz;
		plen = mdl_wheel_mode ? 4 : 3;
		// drop stray bytes until one looks like a packet header
		if (mdl_pos == 0 && !b[3])
			return;
		if (mdl_pos < 3)
			mdl_pkt[mdl_pos] = b;
		mdl_pos = (mdl_pos + 1) & 3;
		if (mdl_pos != 0 && mdl_pos < plen)
			return;
		mdl_pos = 0;
		flags = mdl_pkt[0];
		if (flags[7:6] != 2'b00)
			return;
		dx = int'(mdl_pkt[1]) - (flags[4] ? 256 : 0);
		dy = -(int'(mdl_pkt[2]) - (flags[5] ? 256 : 0));
		dz = 0;
		if (plen == 4) begin
			dz = b[3:0];
			if (dz > 7)
				dz -= 16;
		end
		queue_move(dx, dy, dz, flags[2:0]);
	endfunction

	function automatic void pop_event();
		mouse_move_t ev;
		motion_report_t rep;
		if (mdl_tail == mdl_head)
			return;
		ev = mdl_ring[mdl_tail];
		mdl_tail = ring_succ(mdl_tail);
		if (ev.dx == 0 && ev.dy == 0 && ev.dz == 0 && !ev.chg) begin
			quiet_pops++;
			return;
		end
		rep.x = ev.dx[15:0];
		rep.y = ev.dy[15:0];
		rep.wheel = ev.dz[15:0];
		rep.buttons = ev.buttons;
		pending_reports.push_back(rep);
	endfunction

	// ------------------------------------------------------------------
	// Receiver: random back-pressure, long hold-off on request, checking
	// ------------------------------------------------------------------

	int rx_gap = 0;
	int hold_seen = 0;
	int hold_left = 0;

	always @(posedge clk) begin
		motion_report_t got;
		motion_report_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.x = m_axis_tdata[15:0];
			got.y = m_axis_tdata[31:16];
			got.wheel = m_axis_tdata[47:32];
			got.buttons = m_axis_tdata[50:48];
			reports_seen++;
			if (pending_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: report with nothing expected: x=%h y=%h wheel=%h btn=%0d",
						$realtime, got.x, got.y, got.wheel, got.buttons);
			end else begin
				want = pending_reports.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"%0t: report mismatch: want x=%h y=%h wheel=%h btn=%0d,",
							" got x=%h y=%h wheel=%h btn=%0d"},
							$realtime, want.x, want.y, want.wheel, want.buttons,
							got.x, got.y, got.wheel, got.buttons);
				end
			end
			rx_gap = no_idle ? 0 : $urandom_range(0, 19);
		end
		// pick up a hold-off request from the stimulus and count it down here
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Sender
	// ------------------------------------------------------------------

	// Offer one request after a random gap; hold it until accepted, then
	// advance the model. Call and return on a rising edge.
	task automatic send_req(input logic op, input logic [7:0] b);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= b;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		items_sent++;
		if (op == OP_FEED)
			absorb_byte(b);
		else
			pop_event();
	endtask

	// Stop offering, wait for every expected report, then let any silent
	// work (quiet pop, full-ring merge) finish.
	task automatic settle_block();
		int waited;
		waited = 0;
		s_axis_tvalid <= 1'b0;
		while (pending_reports.size() > 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (pending_reports.size() > 0) begin
			if (mismatches < 10)
				$display("%0t: %0d expected reports never arrived", $realtime,
					pending_reports.size());
			mismatches += pending_reports.size();
			pending_reports.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(input logic v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		mdl_wheel_mode = v;
	endtask

	// Mostly well-formed packets with random content, some truncated,
	// plus stray bytes and pops.
	task automatic run_mixed(input int n);
		int target;
		int pick;
		int cut;
		int unsigned plen;
		logic [7:0] hdr;
		target = items_sent + n;
		while (items_sent < target) begin
			pick = $urandom_range(0, 99);
			plen = mdl_wheel_mode ? 4 : 3;
			if (pick < 45) begin
				hdr = 8'($urandom_range(0, 255));
				hdr[3] = 1'b1;
				if ($urandom_range(0, 7) != 0)
					hdr[7:6] = 2'b00;
				send_req(OP_FEED, hdr);
				cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, plen - 2) : plen - 1;
				repeat (cut) send_req(OP_FEED, 8'($urandom_range(0, 255)));
			end else if (pick < 55) begin
				send_req(OP_FEED, 8'($urandom_range(0, 255)));
			end else begin
				send_req(OP_POP, 8'($urandom_range(0, 255)));
			end
		end
	endtask

	task automatic send_packet(input logic [7:0] hdr, input logic [7:0] bx,
			input logic [7:0] by);
		send_req(OP_FEED, hdr);
		send_req(OP_FEED, bx);
		send_req(OP_FEED, by);
	endtask

	// Fill the ring and keep merging large motion into the newest entry so
	// that dx climbs to the top rail and dy to the bottom one; then pull
	// both back off the rails. Drain with pops while the receiver holds off.
	task automatic run_flood();
		repeat (RING_DEPTH - 1 + FLOOD_MERGES)
			send_packet({5'b00001, 3'($urandom_range(0, 7))},
				8'($urandom_range(240, 255)), 8'($urandom_range(240, 255)));
		// negative dx, positive dy
		repeat (4)
			send_packet({5'b00111, 3'($urandom_range(0, 7))}, 8'h00, 8'h00);
		no_idle = 1'b1;
		hold_req++;
		repeat (RING_DEPTH + 2)
			send_req(OP_POP, 8'h00);
		no_idle = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------

	initial begin
		dir_row_t row;
		int queued_cnt;
		mdl_wheel_mode = 1'b0;
		mdl_pos = 0;
		mdl_buttons = 3'd0;
		mdl_head = 0;
		mdl_tail = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table.
		for (int i = 0; i < DIR_ROWS; i++) begin
			row = dir_table[i];
			if (row.kind == ROW_MODE) begin
				settle_block();
				write_mode(row.data[0]);
			end else begin
				queued_cnt = pending_reports.size();
				send_req(row.op, row.data);
				if (row.kind != ROW_PRED) begin
					while (pending_reports.size() > queued_cnt)
						void'(pending_reports.pop_back());
					if (row.kind == ROW_LIT)
						pending_reports.push_back({row.x, row.y, row.wheel, row.buttons});
				end
			end
		end
		settle_block();

		// Wheel packets with random idling on both sides.
		write_mode(1'b1);
		run_mixed(100);
		settle_block();

		// Short packets back to back, no idling.
		write_mode(1'b0);
		no_idle = 1'b1;
		run_mixed(100);
		no_idle = 1'b0;
		settle_block();

		// Full ring, saturating sums, long receiver stall.
		write_mode(1'b0);
		run_flood();
		settle_block();

		// Wheel packets again, whatever partial packet is left over.
		write_mode(1'b1);
		run_mixed(70);
		settle_block();

		$display("Sent %0d requests over both packet lengths; %0d reports, %0d quiet pops.",
			items_sent, reports_seen, quiet_pops);
		$display("Full-ring merges: %0d, clipped sums: %0d, mismatches: %0d.",
			merge_count, clip_count, mismatches);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+design
design/ps2mq_pkg.sv
design/ps2mq_ram.sv
design/ps2mq_asm.sv
design/ps2mq_ring.sv
design/ps2_mouse_packet_event_queue.sv
tb/tb.sv
